@@ sv/tpi_pkg.sv @@
// shared types and constants for the three-plane intersection pipeline
package tpi_pkg;

  // q16.16 field width
  localparam int FIELD_W = 32;
  // cross product and 2x2 terms, exact
  localparam int XP_W    = 65;
  // split product half width
  localparam int HALF_W  = 32;
  // exact product of a field and a 2x2 term
  localparam int PROD_W  = 98;
  // determinant and numerators, exact sum of three products
  localparam int SUM_W   = 100;
  // extra fraction bits on the numerator: 16 for q16.16 plus one for rounding
  localparam int NUM_SH  = 17;
  // fraction bits dropped when a q32.32 term is brought to q16.16
  localparam int FRAC_W  = 16;
  // divider datapath and quotient widths
  localparam int DIV_W   = 130;
  localparam int QUO_W   = 33;
  localparam int DIV_LAT = QUO_W + 1;
  // pipeline depths of the front modules
  localparam int XP_LAT  = 2;
  localparam int DOT_LAT = 3;
  // accept edge to the edge that takes the result
  localparam int LATENCY = XP_LAT + DOT_LAT + 1 + DIV_LAT + 1;
  // clamp limits as magnitudes
  localparam logic [FIELD_W-1:0] POS_LIMIT = 32'h7fff_ffff;
  localparam logic [FIELD_W-1:0] NEG_LIMIT = 32'h8000_0000;

  // one input transaction: three planes
  typedef struct packed {
    logic signed [FIELD_W-1:0] a_norm_x;
    logic signed [FIELD_W-1:0] a_norm_y;
    logic signed [FIELD_W-1:0] a_norm_z;
    logic signed [FIELD_W-1:0] a_offset;
    logic signed [FIELD_W-1:0] b_norm_x;
    logic signed [FIELD_W-1:0] b_norm_y;
    logic signed [FIELD_W-1:0] b_norm_z;
    logic signed [FIELD_W-1:0] b_offset;
    logic signed [FIELD_W-1:0] c_norm_x;
    logic signed [FIELD_W-1:0] c_norm_y;
    logic signed [FIELD_W-1:0] c_norm_z;
    logic signed [FIELD_W-1:0] c_offset;
  } planes_t;

  // one result transaction
  typedef struct packed {
    logic signed [FIELD_W-1:0] pt_x;
    logic signed [FIELD_W-1:0] pt_y;
    logic signed [FIELD_W-1:0] pt_z;
    logic                      singular;
    logic                      saturated;
  } result_t;

  // cross products of b and c, with plane a carried along
  typedef struct packed {
    logic                    vld;
    logic signed [XP_W-1:0]  px;
    logic signed [XP_W-1:0]  py;
    logic signed [XP_W-1:0]  pz;
    logic signed [XP_W-1:0]  dc;
    logic signed [XP_W-1:0]  db;
    logic signed [XP_W-1:0]  ad;
    logic signed [FIELD_W-1:0] fx;
    logic signed [FIELD_W-1:0] fy;
    logic signed [FIELD_W-1:0] fz;
    logic signed [FIELD_W-1:0] fd;
  } xprod_t;

  // determinant and cramer numerators
  typedef struct packed {
    logic                    vld;
    logic signed [SUM_W-1:0] det;
    logic signed [SUM_W-1:0] nx;
    logic signed [SUM_W-1:0] ny;
    logic signed [SUM_W-1:0] nz;
    logic signed [XP_W-1:0]  px;
    logic signed [XP_W-1:0]  py;
    logic signed [XP_W-1:0]  pz;
  } dot_t;

  // divider lane request and response
  typedef struct packed {
    logic             neg;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_in_t;

  typedef struct packed {
    logic             neg;
    logic             ovf;
    logic [QUO_W-1:0] quo;
  } div_out_t;

endpackage

@@ sv/three_plane_intersection_point.sv @@
// top level: three-plane intersection point pipeline
//
//   channel  | ports                   | handshake
//   ---------+-------------------------+--------------------------------
//   input    | start, busy, planes     | taken when start && !busy
//   result   | done, result            | one-cycle strobe, no backpressure
//
// done and result leave the result register behind the cross, dot, prep and divider
// stages, one transaction per cycle sustained; the 33 quotient-bit stages
// of the divider lanes set the depth. busy is high only during reset. rst
// clears every valid bit at once, transactions in flight are dropped. the
// result side has no stall.
module three_plane_intersection_point import tpi_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  planes_t planes,
  output logic    done,
  output result_t result
);

  typedef struct packed {
    logic                        nc;
    logic                        xsat;
    logic [2:0][FIELD_W-1:0]     xpt;
  } side_t;

  xprod_t   xprod;
  dot_t     dot;
  div_in_t  dreq [0:2];
  div_out_t drsp [0:2];
  side_t    prep_side;
  side_t    side_next;
  logic     prep_vld;
  side_t    side [0:DIV_LAT-1];
  logic     side_vld [0:DIV_LAT-1];

  logic signed [SUM_W-1:0] num [0:2];
  logic signed [XP_W-1:0]  xp [0:2];
  logic [SUM_W-1:0]        nmag [0:2];
  logic [SUM_W-1:0]        dmag;
  logic [XP_W-1:0]         xmag [0:2];
  logic [XP_W:0]           xsum [0:2];
  logic [XP_W-FRAC_W-1:0]  xrnd [0:2];
  logic [FIELD_W-1:0]      xlim [0:2];
  logic [FIELD_W-1:0]      xm [0:2];

  logic [QUO_W:0]          qsum [0:2];
  logic [QUO_W-1:0]        qr [0:2];
  logic [FIELD_W-1:0]      qlim [0:2];
  logic [FIELD_W-1:0]      qm [0:2];
  logic [FIELD_W-1:0]      qval [0:2];
  logic [2:0]              qsat;

  assign busy = rst;

  tpi_cross u_cross (
    .clk    (clk),
    .rst    (rst),
    .in_vld (start && !busy),
    .planes (planes),
    .xprod  (xprod)
  );

  tpi_dot u_dot (
    .clk   (clk),
    .rst   (rst),
    .xprod (xprod),
    .dot   (dot)
  );

  // magnitudes and signs, plus the rounded cross product for a flat det
  always_comb begin
    num[0] = dot.nx;
    num[1] = dot.ny;
    num[2] = dot.nz;
    xp[0]  = dot.px;
    xp[1]  = dot.py;
    xp[2]  = dot.pz;
    dmag   = dot.det[SUM_W-1] ? -dot.det : dot.det;
    side_next.nc   = (dot.det == '0);
    side_next.xsat = 1'b0;
    for (int l = 0; l < 3; l++) begin
      nmag[l] = num[l][SUM_W-1] ? -num[l] : num[l];
      xmag[l] = xp[l][XP_W-1] ? -xp[l] : xp[l];
      xsum[l] = (XP_W+1)'(xmag[l]) + (XP_W+1)'(1 << (FRAC_W-1));
      xrnd[l] = xsum[l][XP_W-1:FRAC_W];
      xlim[l] = xp[l][XP_W-1] ? NEG_LIMIT : POS_LIMIT;
      if (xrnd[l] > (XP_W-FRAC_W)'(xlim[l])) begin
        xm[l] = xlim[l];
        side_next.xsat = 1'b1;
      end else begin
        xm[l] = xrnd[l][FIELD_W-1:0];
      end
      side_next.xpt[l] = xp[l][XP_W-1] ? -xm[l] : xm[l];
    end
  end

  // prep stage register feeding the divider lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      prep_vld <= 1'b0;
    end else begin
      prep_vld <= dot.vld;
    end
    prep_side <= side_next;
    for (int l = 0; l < 3; l++) begin
      dreq[l].neg <= num[l][SUM_W-1] ^ dot.det[SUM_W-1];
      dreq[l].num <= DIV_W'({nmag[l], {NUM_SH{1'b0}}});
      dreq[l].den <= DIV_W'(dmag);
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    tpi_div u_div (
      .clk (clk),
      .req (dreq[l]),
      .rsp (drsp[l])
    );
  end

  // side line matched to the divider depth
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        side_vld[i] <= 1'b0;
      end
    end else begin
      side_vld[0] <= prep_vld;
      for (int i = 1; i < DIV_LAT; i++) begin
        side_vld[i] <= side_vld[i-1];
      end
    end
    side[0] <= prep_side;
    for (int i = 1; i < DIV_LAT; i++) begin
      side[i] <= side[i-1];
    end
  end

  // round half away from zero, then clamp to q16.16
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      qsum[l] = (QUO_W+1)'(drsp[l].quo) + (QUO_W+1)'(1);
      qr[l]   = qsum[l][QUO_W:1];
      qlim[l] = drsp[l].neg ? NEG_LIMIT : POS_LIMIT;
      if (drsp[l].ovf || qr[l] > QUO_W'(qlim[l])) begin
        qm[l]   = qlim[l];
        qsat[l] = 1'b1;
      end else begin
        qm[l]   = qr[l][FIELD_W-1:0];
        qsat[l] = 1'b0;
      end
      qval[l] = drsp[l].neg ? -qm[l] : qm[l];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= side_vld[DIV_LAT-1];
    end
    result.singular <= side[DIV_LAT-1].nc;
    if (side[DIV_LAT-1].nc) begin
      result.pt_x      <= side[DIV_LAT-1].xpt[0];
      result.pt_y      <= side[DIV_LAT-1].xpt[1];
      result.pt_z      <= side[DIV_LAT-1].xpt[2];
      result.saturated <= side[DIV_LAT-1].xsat;
    end else begin
      result.pt_x      <= qval[0];
      result.pt_y      <= qval[1];
      result.pt_z      <= qval[2];
      result.saturated <= |qsat;
    end
  end

endmodule

@@ sv/tpi_cross.sv @@
// cross products of the second and third planes, two stages
module tpi_cross import tpi_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_vld,
  input  planes_t planes,
  output xprod_t  xprod
);

  logic                      vld1;
  logic signed [2*FIELD_W-1:0] prod [0:11];
  logic signed [FIELD_W-1:0] fx1, fy1, fz1, fd1;

  // stage 1: twelve 32x32 products
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else begin
      vld1 <= in_vld;
    end
    prod[0]  <= planes.b_norm_y * planes.c_norm_z;
    prod[1]  <= planes.b_norm_z * planes.c_norm_y;
    prod[2]  <= planes.b_norm_z * planes.c_norm_x;
    prod[3]  <= planes.b_norm_x * planes.c_norm_z;
    prod[4]  <= planes.b_norm_x * planes.c_norm_y;
    prod[5]  <= planes.b_norm_y * planes.c_norm_x;
    prod[6]  <= planes.b_offset * planes.c_norm_z;
    prod[7]  <= planes.c_offset * planes.b_norm_z;
    prod[8]  <= planes.b_offset * planes.c_norm_y;
    prod[9]  <= planes.c_offset * planes.b_norm_y;
    prod[10] <= planes.b_norm_x * planes.c_offset;
    prod[11] <= planes.c_norm_x * planes.b_offset;
    fx1 <= planes.a_norm_x;
    fy1 <= planes.a_norm_y;
    fz1 <= planes.a_norm_z;
    fd1 <= planes.a_offset;
  end

  // stage 2: differences, exact in 65 bits
  always_ff @(posedge clk) begin
    if (rst) begin
      xprod.vld <= 1'b0;
    end else begin
      xprod.vld <= vld1;
    end
    xprod.px <= XP_W'(prod[0])  - XP_W'(prod[1]);
    xprod.py <= XP_W'(prod[2])  - XP_W'(prod[3]);
    xprod.pz <= XP_W'(prod[4])  - XP_W'(prod[5]);
    xprod.dc <= XP_W'(prod[6])  - XP_W'(prod[7]);
    xprod.db <= XP_W'(prod[8])  - XP_W'(prod[9]);
    xprod.ad <= XP_W'(prod[10]) - XP_W'(prod[11]);
    xprod.fx <= fx1;
    xprod.fy <= fy1;
    xprod.fz <= fz1;
    xprod.fd <= fd1;
  end

endmodule

@@ sv/tpi_dot.sv @@
// determinant and numerators: split products, recombine, three-term sums
module tpi_dot import tpi_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  xprod_t xprod,
  output dot_t   dot
);

  logic signed [FIELD_W-1:0] fop [0:11];
  logic signed [XP_W-1:0]    vop [0:11];
  logic signed [XP_W-1:0]    part_lo [0:11];
  logic signed [XP_W-1:0]    part_hi [0:11];
  logic signed [PROD_W-1:0]  prod [0:11];
  logic                      vld_a, vld_b;
  logic signed [XP_W-1:0]    px_a, py_a, pz_a, px_b, py_b, pz_b;

  // operand pairs: det, then x, y and z numerators
  always_comb begin
    fop[0]  = xprod.fx; vop[0]  = xprod.px;
    fop[1]  = xprod.fy; vop[1]  = xprod.py;
    fop[2]  = xprod.fz; vop[2]  = xprod.pz;
    fop[3]  = xprod.fy; vop[3]  = xprod.dc;
    fop[4]  = xprod.fz; vop[4]  = xprod.db;
    fop[5]  = xprod.fd; vop[5]  = xprod.px;
    fop[6]  = xprod.fx; vop[6]  = xprod.dc;
    fop[7]  = xprod.fz; vop[7]  = xprod.ad;
    fop[8]  = xprod.fd; vop[8]  = xprod.py;
    fop[9]  = xprod.fx; vop[9]  = xprod.db;
    fop[10] = xprod.fy; vop[10] = xprod.ad;
    fop[11] = xprod.fd; vop[11] = xprod.pz;
  end

  // stage a: low and high partial products per term
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
    end else begin
      vld_a <= xprod.vld;
    end
    for (int i = 0; i < 12; i++) begin
      part_lo[i] <= fop[i] * $signed({1'b0, vop[i][HALF_W-1:0]});
      part_hi[i] <= fop[i] * $signed(vop[i][XP_W-1:HALF_W]);
    end
    px_a <= xprod.px;
    py_a <= xprod.py;
    pz_a <= xprod.pz;
  end

  // stage b: recombine halves
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_b <= 1'b0;
    end else begin
      vld_b <= vld_a;
    end
    for (int i = 0; i < 12; i++) begin
      prod[i] <= (PROD_W'(part_hi[i]) <<< HALF_W) + PROD_W'(part_lo[i]);
    end
    px_b <= px_a;
    py_b <= py_a;
    pz_b <= pz_a;
  end

  // stage c: triple product and cramer numerators
  always_ff @(posedge clk) begin
    if (rst) begin
      dot.vld <= 1'b0;
    end else begin
      dot.vld <= vld_b;
    end
    dot.det <= SUM_W'(prod[0]) + SUM_W'(prod[1]) + SUM_W'(prod[2]);
    dot.nx  <= SUM_W'(prod[3]) - SUM_W'(prod[4]) - SUM_W'(prod[5]);
    dot.ny  <= -SUM_W'(prod[6]) - SUM_W'(prod[7]) - SUM_W'(prod[8]);
    dot.nz  <= SUM_W'(prod[9]) + SUM_W'(prod[10]) - SUM_W'(prod[11]);
    dot.px  <= px_b;
    dot.py  <= py_b;
    dot.pz  <= pz_b;
  end

endmodule

@@ sv/tpi_div.sv @@
// pipelined restoring divider lane, one quotient bit per stage
module tpi_div import tpi_pkg::*; (
  input  logic     clk,
  input  div_in_t  req,
  output div_out_t rsp
);

  logic [DIV_W-1:0] rem [0:QUO_W-1];
  logic [DIV_W-1:0] den [0:QUO_W-1];
  logic [QUO_W-1:0] quo [0:QUO_W];
  logic             neg [0:QUO_W];
  logic             ovf [0:QUO_W];

  // entry stage: flag quotients too wide for the result
  always_ff @(posedge clk) begin
    rem[0] <= req.num;
    den[0] <= req.den;
    neg[0] <= req.neg;
    ovf[0] <= req.num >= (req.den << QUO_W);
    quo[0] <= '0;
  end

  // one stage per quotient bit, msb first
  for (genvar j = 1; j <= QUO_W; j++) begin : g_step
    logic [DIV_W-1:0] trial;
    logic             take;

    assign trial = den[j-1] << (QUO_W - j);
    assign take  = rem[j-1] >= trial;

    always_ff @(posedge clk) begin
      quo[j] <= {quo[j-1][QUO_W-2:0], take};
      neg[j] <= neg[j-1];
      ovf[j] <= ovf[j-1];
    end

    if (j < QUO_W) begin : g_rem
      always_ff @(posedge clk) begin
        rem[j] <= take ? rem[j-1] - trial : rem[j-1];
        den[j] <= den[j-1];
      end
    end
  end

  assign rsp.neg = neg[QUO_W];
  assign rsp.ovf = ovf[QUO_W];
  assign rsp.quo = quo[QUO_W];

endmodule

@@ sv/tpi_check.sv @@
// port-level checker for the three-plane intersection block, with its bind
module tpi_check import tpi_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input planes_t planes,
  input logic    done,
  input result_t result
);

  // busy only follows reset
  a_busy_rst: assert property (@(posedge clk) busy == rst)
    else $error("busy outside reset");

  // every accepted transaction comes out after the fixed latency
  a_lat_fwd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("result missing after accept");

  // no result without a matching accept
  a_lat_back: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without accept");

  // zero second normal: flat determinant and a zero cross product
  a_flat_b: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && planes.b_norm_x == 0 && planes.b_norm_y == 0 &&
     planes.b_norm_z == 0) |-> ##LATENCY
    (result.singular && !result.saturated && result.pt_x == 0 &&
     result.pt_y == 0 && result.pt_z == 0))
    else $error("zero normal not flagged");

  // zero first normal: flat determinant
  a_flat_a: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && planes.a_norm_x == 0 && planes.a_norm_y == 0 &&
     planes.a_norm_z == 0) |-> ##LATENCY result.singular)
    else $error("zero first normal not flagged");

endmodule

bind three_plane_intersection_point tpi_check u_check (.*);
